FILE: hdl/tpfd_pkg.sv
// ----------------------------------------------------------------------------
// tpfd_pkg
// Types, thresholds and helpers shared by the fall detector modules.
// ----------------------------------------------------------------------------
package tpfd_pkg;

	// sensitivity levels
	localparam logic [1:0] SENS_OFF  = 2'd0;
	localparam logic [1:0] SENS_LOW  = 2'd1;
	localparam logic [1:0] SENS_MID  = 2'd2;
	localparam logic [1:0] SENS_HIGH = 2'd3;

	// squared thresholds, units of (1/128 m/s^2)^2
	localparam logic [31:0] STILL_SQ     = 32'd65536;     // 2 m/s^2
	localparam logic [31:0] FF_SQ_LOW    = 32'd1327104;   // 9 m/s^2
	localparam logic [31:0] FF_SQ_MID    = 32'd589824;    // 6 m/s^2
	localparam logic [31:0] FF_SQ_HIGH   = 32'd147456;    // 3 m/s^2
	localparam logic [31:0] IMP_SQ_LOW   = 32'd10240000;  // mag*1 > 3200^2
	localparam logic [31:0] IMP_SQ_MID   = 32'd2560000;   // mag*4 > 3200^2
	localparam logic [31:0] IMP_SQ_HIGH  = 32'd1137777;   // mag*9 > 3200^2
	localparam logic [31:0] SEV4_SQ      = 32'd26214400;  // 40 m/s^2
	localparam logic [31:0] SEV3_SQ      = 32'd14745600;  // 30 m/s^2

	localparam logic [2:0] SEV_NONE = 3'd0;
	localparam logic [2:0] SEV_LOW  = 3'd2;
	localparam logic [2:0] SEV_MID  = 3'd3;
	localparam logic [2:0] SEV_HIGH = 3'd4;

	// per-sample compare results; ff/imp indexed by sensitivity level - 1
	typedef struct packed {
		logic       still;
		logic [2:0] ff;
		logic [2:0] imp;
		logic       sev4;
		logic       sev3;
	} flags_t;

	typedef struct packed {
		logic   valid;
		flags_t flags;
	} cell_t;

	function automatic logic pick_level(input logic [2:0] v, input logic [1:0] sens);
		logic r;
		unique case (sens)
			SENS_LOW:  r = v[0];
			SENS_MID:  r = v[1];
			SENS_HIGH: r = v[2];
			default:   r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/tpfd_mag.sv
// ----------------------------------------------------------------------------
// tpfd_mag
// Two-stage squared magnitude and threshold compare of one sample.
// ----------------------------------------------------------------------------
module tpfd_mag #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output tpfd_pkg::flags_t               out_flags
);
	import tpfd_pkg::*;

	localparam int W     = SAMPLE_WIDTH;
	localparam int SQ_W  = 2 * W;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > 32) ? SUM_W : 32;

	function automatic logic [W-1:0] mag_abs(input logic [W-1:0] v);
		return v[W-1] ? W'(~v + W'(1)) : v;
	endfunction

	logic            valid_s1;
	logic [SQ_W-1:0] sq_x_s1, sq_y_s1, sq_z_s1;
	logic            valid_s2;
	flags_t          flags_s2;

	logic            ready_s1, ready_s2;
	logic [W-1:0]    ax, ay, az;
	logic [SUM_W-1:0] sum;
	logic [CMP_W-1:0] mag;
	flags_t          flags_d;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		ax  = mag_abs(accel_x);
		ay  = mag_abs(accel_y);
		az  = mag_abs(accel_z);
		sum = SUM_W'(sq_x_s1) + SUM_W'(sq_y_s1) + SUM_W'(sq_z_s1);
		mag = CMP_W'(sum);
		flags_d.still  = mag < CMP_W'(STILL_SQ);
		flags_d.ff[0]  = mag < CMP_W'(FF_SQ_LOW);
		flags_d.ff[1]  = mag < CMP_W'(FF_SQ_MID);
		flags_d.ff[2]  = mag < CMP_W'(FF_SQ_HIGH);
		flags_d.imp[0] = mag > CMP_W'(IMP_SQ_LOW);
		flags_d.imp[1] = mag > CMP_W'(IMP_SQ_MID);
		flags_d.imp[2] = mag > CMP_W'(IMP_SQ_HIGH);
		flags_d.sev4   = mag > CMP_W'(SEV4_SQ);
		flags_d.sev3   = mag > CMP_W'(SEV3_SQ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			sq_x_s1 <= SQ_W'(ax) * SQ_W'(ax);
			sq_y_s1 <= SQ_W'(ay) * SQ_W'(ay);
			sq_z_s1 <= SQ_W'(az) * SQ_W'(az);
		end
		if (ready_s2 && valid_s1) flags_s2 <= flags_d;
	end

	assign out_valid = valid_s2;
	assign out_flags = flags_s2;

endmodule

FILE: hdl/tpfd_cell.sv
// ----------------------------------------------------------------------------
// tpfd_cell
// One history cell: holds a sample's flags, takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module tpfd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  tpfd_pkg::cell_t d,
	output tpfd_pkg::cell_t q
);
	import tpfd_pkg::*;

	logic   valid_q;
	flags_t flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) flags_q <= d.flags;
	end

	assign q.valid = valid_q;
	assign q.flags = flags_q;

endmodule

FILE: hdl/three_phase_fall_detector.sv
// ----------------------------------------------------------------------------
// three_phase_fall_detector
// Freefall, impact and stillness pattern detector on accelerometer samples.
// ----------------------------------------------------------------------------
// Input stream s_*: one request per sample, tdata = accel_x, accel_y, accel_z
// (signed, SAMPLE_WIDTH bits each, 1/128 m/s^2). Output stream m_*: exactly
// one result per sample, tdata = fall flag, severity.
// Config channel cfg_*: sensitivity, 0 is stored as 1; always ready, write
// only while no sample is in flight.
// Each accepted sample passes the registered steps square, sum and compare,
// and decision, in that order, before its result shows on m_tvalid.
// Throughput: one sample per cycle while m_tready is high.
// The newest sample's flags are judged against two history cells that
// shift once per sample; the first two results after reset report no fall.
// Reset clears the pipeline and the history and sets sensitivity to 2.
// When m_tready is low the result holds; s_tready stays high until every
// stage holds a sample, then follows m_tready.
// ----------------------------------------------------------------------------
module three_phase_fall_detector #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// accel_x, accel_y, accel_z, zero pad to bytes
	input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// fall, severity[2:0], zero pad
	output logic [7:0]                                 m_tdata,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [1:0]                                 cfg_data
);
	import tpfd_pkg::*;

	localparam int W = SAMPLE_WIDTH;

	logic [1:0] sens_q;
	logic       m_valid_q;
	logic       fall_q;
	logic [2:0] sev_q;

	logic   mag_valid, mag_ready, advance;
	flags_t mag_flags;
	cell_t  newest, prev_c, older_c;
	logic   fall_d;
	logic [2:0] sev_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= SENS_MID;
		end else if (cfg_valid) begin
			sens_q <= (cfg_data == SENS_OFF) ? SENS_LOW : cfg_data;
		end
	end

	tpfd_mag #(.SAMPLE_WIDTH(W)) u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.accel_x   ($signed(s_tdata[W-1:0])),
		.accel_y   ($signed(s_tdata[2*W-1:W])),
		.accel_z   ($signed(s_tdata[3*W-1:2*W])),
		.out_valid (mag_valid),
		.out_ready (mag_ready),
		.out_flags (mag_flags)
	);

	assign mag_ready = !m_valid_q || m_tready;
	assign advance   = mag_valid && mag_ready;

	assign newest.valid = 1'b1;
	assign newest.flags = mag_flags;

	tpfd_cell u_cell_prev (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (advance),
		.d      (newest),
		.q      (prev_c)
	);

	tpfd_cell u_cell_older (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (advance),
		.d      (prev_c),
		.q      (older_c)
	);

	always_comb begin
		fall_d = prev_c.valid && older_c.valid
			&& pick_level(older_c.flags.ff, sens_q)
			&& pick_level(prev_c.flags.imp, sens_q)
			&& mag_flags.still;
		priority if (!fall_d)              sev_d = SEV_NONE;
		else if (prev_c.flags.sev4)        sev_d = SEV_HIGH;
		else if (prev_c.flags.sev3)        sev_d = SEV_MID;
		else                               sev_d = SEV_LOW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (mag_ready) begin
			m_valid_q <= mag_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fall_q <= fall_d;
			sev_q  <= sev_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, sev_q, fall_q};

endmodule

FILE: hdl/tpfd_checker.sv
// ----------------------------------------------------------------------------
// tpfd_checker
// Port-level checks on the fall detector result stream.
// ----------------------------------------------------------------------------
module tpfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	import tpfd_pkg::*;

	a_sev_matches_fall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] != SEV_NONE)))
		else $error("severity disagrees with fall flag");

	a_sev_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] == SEV_NONE || m_tdata[3:1] == SEV_LOW
			|| m_tdata[3:1] == SEV_MID || m_tdata[3:1] == SEV_HIGH))
		else $error("severity code out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:4] == 4'b0000))
		else $error("result pad bits not zero");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind three_phase_fall_detector tpfd_checker u_tpfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
